@@ hw/rtl/dfr_pkg.sv @@
// Package for the byte-stuffed packet deframer.
// Holds framing codes, status and state encodings, and the control structs.
// Depends on nothing; the deframer top, datapath and controller import it.
`timescale 1ns / 1ps

package dfr_pkg;

  localparam int unsigned HDR_LEN = 5;
  localparam logic [7:0] CODE_START = 8'h23;
  localparam logic [7:0] CODE_END = 8'h2B;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_SHORT    = 2'd1,
    STATUS_OVERFLOW = 2'd2
  } dfr_status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD
  } dfr_state_e;

  typedef struct packed {
    logic accept;
    logic rd_en;
    logic load_out;
  } dfr_cmd_t;

  typedef struct packed {
    logic close_pkt;
    logic out_free;
    logic last;
  } dfr_sts_t;

  typedef struct packed {
    logic [2:0] hdr_flags;
    logic [4:0] message_id;
    logic [7:0] target_service;
    logic [7:0] source_service;
    logic [7:0] packet_number;
    logic [7:0] crc_byte;
    logic [7:0] payload_byte;
    logic       payload_valid;
    logic       last_of_packet;
    logic [1:0] status;
  } dfr_result_t;

endpackage

@@ hw/rtl/dfr_if.sv @@
// Valid/ready channel interfaces for the byte-stuffed packet deframer.
// The input channel carries one received byte, the output channel one result.
`timescale 1ns / 1ps

interface dfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface dfr_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] hdr_flags;
  logic [4:0] message_id;
  logic [7:0] target_service;
  logic [7:0] source_service;
  logic [7:0] packet_number;
  logic [7:0] crc_byte;
  logic [7:0] payload_byte;
  logic       payload_valid;
  logic       last_of_packet;
  logic [1:0] status;

  modport source (
    output valid, output hdr_flags, output message_id, output target_service,
    output source_service, output packet_number, output crc_byte,
    output payload_byte, output payload_valid, output last_of_packet, output status,
    input ready
  );
  modport sink (
    input valid, input hdr_flags, input message_id, input target_service,
    input source_service, input packet_number, input crc_byte,
    input payload_byte, input payload_valid, input last_of_packet, input status,
    output ready
  );
endinterface

@@ hw/rtl/byte_stuffed_packet_deframer.sv @@
// Byte-stuffed packet deframer. Outside a readout one byte is taken per cycle.
// The byte that closes a packet starts a readout: each result is first read
// from the packet store (ST_READ, registered read), then loaded into the output
// register (ST_LOAD) once it is free, so input is held off until the last is loaded.
// Reset clears the framing flags, byte count, controller and output valid;
// the packet store is not cleared.
`timescale 1ns / 1ps

module byte_stuffed_packet_deframer #(
  parameter int unsigned BUFFER_DEPTH = 64
) (
  input logic       clk_i,
  input logic       rst_ni,
  dfr_in_if.sink    rx_i,
  dfr_out_if.source res_o
);
  import dfr_pkg::*;

  dfr_cmd_t    cmd;
  dfr_sts_t    sts;
  dfr_result_t result;

  dfr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (rx_i.valid),
    .in_ready_o (rx_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dfr_datapath #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_byte_i   (rx_i.rx_byte),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (res_o.ready),
    .out_valid_o (res_o.valid),
    .result_o    (result)
  );

  assign res_o.hdr_flags      = result.hdr_flags;
  assign res_o.message_id     = result.message_id;
  assign res_o.target_service = result.target_service;
  assign res_o.source_service = result.source_service;
  assign res_o.packet_number  = result.packet_number;
  assign res_o.crc_byte       = result.crc_byte;
  assign res_o.payload_byte   = result.payload_byte;
  assign res_o.payload_valid  = result.payload_valid;
  assign res_o.last_of_packet = result.last_of_packet;
  assign res_o.status         = result.status;

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> sts.out_free)
    else $error("Result loaded while the output register was still held.");

  a_close_stalls_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rx_i.valid && rx_i.ready && sts.close_pkt) |=> (!rx_i.ready && cmd.rd_en))
    else $error("Closing item did not start a readout.");

  a_last_resumes_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.load_out && sts.last) |=> (rx_i.ready && res_o.valid && res_o.last_of_packet))
    else $error("Final result did not end the readout.");

endmodule

@@ hw/rtl/dfr_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module dfr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/dfr_datapath.sv @@
// Datapath of the deframer: framing flags, packet store, header registers,
// readout pointer and result register. Depends on dfr_pkg and dfr_ram.
`timescale 1ns / 1ps

module dfr_datapath #(
  parameter int unsigned BUFFER_DEPTH = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [7:0]          rx_byte_i,
  input  dfr_pkg::dfr_cmd_t   cmd_i,
  output dfr_pkg::dfr_sts_t   sts_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output dfr_pkg::dfr_result_t result_o
);
  import dfr_pkg::*;

  localparam int unsigned AW = $clog2(BUFFER_DEPTH);
  localparam int unsigned CW = $clog2(BUFFER_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(BUFFER_DEPTH);
  localparam logic [CW-1:0] HDR_C = CW'(HDR_LEN);

  logic          start_q, start_d;
  logic          end_q, end_d;
  logic          inpkt_q, inpkt_d;
  logic          ovf_q, ovf_d;
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] ptr_q, ptr_d;
  logic [7:0]    hdr_q [HDR_LEN];
  logic          out_valid_q;
  dfr_result_t   result_q;

  logic          push, clr, close;
  logic [CW-1:0] cnt_base;
  logic          ovf_base, full, wr_en;
  logic [7:0]    rd_data;
  logic          has_pl, last;
  logic [7:0]    hdr_m [HDR_LEN];
  dfr_status_e   status;

  // Framing rules for one received byte.
  always_comb begin
    start_d = start_q;
    end_d   = end_q;
    inpkt_d = inpkt_q;
    push    = 1'b0;
    clr     = 1'b0;
    close   = 1'b0;
    if (rx_byte_i == CODE_START) begin
      if (start_q) begin
        if (inpkt_q) begin
          push    = 1'b1;
          start_d = 1'b0;
        end
      end else if (end_q) begin
        if (inpkt_q) begin
          close   = 1'b1;
          inpkt_d = 1'b0;
        end
      end else begin
        start_d = 1'b1;
      end
      end_d = 1'b0;
    end else if (rx_byte_i == CODE_END) begin
      if (start_q) begin
        inpkt_d = 1'b1;
      end
      if (end_q) begin
        if (start_q || inpkt_q) begin
          push  = 1'b1;
          end_d = 1'b0;
        end
      end else begin
        end_d = 1'b1;
      end
      start_d = 1'b0;
    end else begin
      if (start_q) begin
        clr     = 1'b1;
        start_d = 1'b0;
        inpkt_d = 1'b1;
      end else if (end_q) begin
        clr     = 1'b1;
        end_d   = 1'b0;
        inpkt_d = 1'b0;
      end
      push = inpkt_d;
    end
  end

  assign cnt_base = clr ? '0 : count_q;
  assign ovf_base = clr ? 1'b0 : ovf_q;
  assign full     = (cnt_base == DEPTH_C);
  assign wr_en    = cmd_i.accept && push && !full;

  assign has_pl = (count_q > HDR_C);
  assign last   = !has_pl || (CW'(ptr_q) == count_q - CW'(1));

  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    ptr_d   = ptr_q;
    if (cmd_i.load_out) begin
      if (last) begin
        count_d = '0;
        ovf_d   = 1'b0;
        ptr_d   = AW'(HDR_LEN);
      end else begin
        ptr_d = ptr_q + AW'(1);
      end
    end else if (cmd_i.accept) begin
      count_d = (push && !full) ? cnt_base + CW'(1) : cnt_base;
      ovf_d   = ovf_base || (push && full);
    end
  end

  always_comb begin
    for (int k = 0; k < HDR_LEN; k++) begin
      hdr_m[k] = (CW'(k) < count_q) ? hdr_q[k] : 8'h00;
    end
    if (ovf_q) begin
      status = STATUS_OVERFLOW;
    end else if (count_q < HDR_C) begin
      status = STATUS_SHORT;
    end else begin
      status = STATUS_OK;
    end
  end

  dfr_ram #(
    .WIDTH(8),
    .DEPTH(BUFFER_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (cnt_base[AW-1:0]),
    .wdata_i (rx_byte_i),
    .re_i    (cmd_i.rd_en),
    .raddr_i (ptr_q),
    .rdata_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q     <= 1'b0;
      end_q       <= 1'b0;
      inpkt_q     <= 1'b0;
      ovf_q       <= 1'b0;
      count_q     <= '0;
      ptr_q       <= AW'(HDR_LEN);
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        start_q <= start_d;
        end_q   <= end_d;
        inpkt_q <= inpkt_d;
      end
      ovf_q   <= ovf_d;
      count_q <= count_d;
      ptr_q   <= ptr_d;
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en && (cnt_base < HDR_C)) begin
      hdr_q[cnt_base[2:0]] <= rx_byte_i;
    end
    if (cmd_i.load_out) begin
      result_q.hdr_flags      <= hdr_m[0][2:0];
      result_q.message_id     <= hdr_m[0][7:3];
      result_q.target_service <= hdr_m[1];
      result_q.source_service <= hdr_m[2];
      result_q.packet_number  <= hdr_m[3];
      result_q.crc_byte       <= hdr_m[4];
      result_q.payload_byte   <= has_pl ? rd_data : 8'h00;
      result_q.payload_valid  <= has_pl;
      result_q.last_of_packet <= last;
      result_q.status         <= status;
    end
  end

  assign sts_o.close_pkt = close;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;
  assign sts_o.last      = last;
  assign out_valid_o     = out_valid_q;
  assign result_o        = result_q;

endmodule

@@ hw/rtl/dfr_ctrl.sv @@
// Controller of the deframer: takes bytes while idle and sequences the
// packet readout, one store read and one result load per item. Uses dfr_pkg.
`timescale 1ns / 1ps

module dfr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  dfr_pkg::dfr_sts_t sts_i,
  output dfr_pkg::dfr_cmd_t cmd_o
);
  import dfr_pkg::*;

  dfr_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i && sts_i.close_pkt) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_LOAD;
      end
      ST_LOAD: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = sts_i.last ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule
